// ===== design/irc_tok_pkg.sv =====
package irc_tok_pkg;

    // Characters that steer the parser.
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CASE_GAP = 8'h20;

    // Token kinds.
    localparam logic [2:0] KIND_PREFIX = 3'd0;
    localparam logic [2:0] KIND_CMD    = 3'd1;
    localparam logic [2:0] KIND_PARAM  = 3'd2;
    localparam logic [2:0] KIND_TRAIL  = 3'd3;
    localparam logic [2:0] KIND_EOL    = 3'd4;

    // End-of-line status codes.
    localparam logic [2:0] STAT_OK          = 3'd0;
    localparam logic [2:0] STAT_EMPTY       = 3'd1;
    localparam logic [2:0] STAT_PREFIX_NOSP = 3'd2;
    localparam logic [2:0] STAT_PREFIX_ONLY = 3'd3;
    localparam logic [2:0] STAT_NO_CMD      = 3'd4;

    localparam logic [7:0] PARAM_MAX = 8'hFF;

    // Default number of entries in the result queue.
    localparam int OUTQ_DEPTH_DEF = 4;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_PREFIX = 3'd1,
        PH_PRECMD = 3'd2,
        PH_CMD    = 3'd3,
        PH_SEP    = 3'd4,
        PH_PARAM  = 3'd5,
        PH_TRAIL  = 3'd6,
        PH_ERROR  = 3'd7
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic [2:0] token_kind;
        logic       token_start;
        logic [2:0] line_status;
        logic [7:0] param_total;
        logic       run_last;
    } result_t;

    typedef struct packed {
        phase_t     phase;
        logic       cr_pending;
        logic [2:0] err;
        logic [7:0] cnt;
    } state_t;

    localparam state_t ST_RESET = '{
        phase: PH_START, cr_pending: 1'b0, err: STAT_OK, cnt: 8'd0
    };

    // Results written into the queue together, first result in r0.
    typedef struct packed {
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } push_t;

    // Outcome of feeding one line byte to the phase machine.
    typedef struct packed {
        logic       emit;
        result_t    res;
        phase_t     phase;
        logic [2:0] err;
        logic [7:0] cnt;
    } take_t;

    function automatic logic [7:0] upcase(logic [7:0] c);
        logic [7:0] u;
        u = c;
        if (c >= CH_LOW_A && c <= CH_LOW_Z)
        begin
            u = c - CASE_GAP;
        end
        return u;
    endfunction

    function automatic logic [7:0] sat_inc(logic [7:0] v);
        return (v == PARAM_MAX) ? v : v + 8'd1;
    endfunction

    function automatic result_t mk_res(logic [7:0] data, logic has, logic [2:0] kind,
                                       logic start);
        result_t r;
        r = '0;
        r.data_byte   = data;
        r.has_byte    = has;
        r.token_kind  = kind;
        r.token_start = start;
        return r;
    endfunction

    function automatic take_t take_byte(phase_t ph, logic [2:0] err, logic [7:0] cnt,
                                        logic [7:0] c);
        take_t t;
        t.emit  = 1'b0;
        t.res   = '0;
        t.phase = ph;
        t.err   = err;
        t.cnt   = cnt;
        unique case (ph)
            PH_START:
            begin
                if (c == CH_COLON)
                begin
                    t.emit  = 1'b1;
                    t.res   = mk_res(8'd0, 1'b0, KIND_PREFIX, 1'b1);
                    t.phase = PH_PREFIX;
                end
                else if (c == CH_SPACE)
                begin
                    t.err   = STAT_NO_CMD;
                    t.phase = PH_ERROR;
                end
                else
                begin
                    t.emit  = 1'b1;
                    t.res   = mk_res(upcase(c), 1'b1, KIND_CMD, 1'b1);
                    t.phase = PH_CMD;
                end
            end
            PH_PREFIX:
            begin
                if (c == CH_SPACE)
                begin
                    t.phase = PH_PRECMD;
                end
                else
                begin
                    t.emit = 1'b1;
                    t.res  = mk_res(c, 1'b1, KIND_PREFIX, 1'b0);
                end
            end
            PH_PRECMD:
            begin
                if (c != CH_SPACE)
                begin
                    t.emit  = 1'b1;
                    t.res   = mk_res(upcase(c), 1'b1, KIND_CMD, 1'b1);
                    t.phase = PH_CMD;
                end
            end
            PH_CMD:
            begin
                if (c == CH_SPACE)
                begin
                    t.phase = PH_SEP;
                end
                else
                begin
                    t.emit = 1'b1;
                    t.res  = mk_res(upcase(c), 1'b1, KIND_CMD, 1'b0);
                end
            end
            PH_SEP:
            begin
                if (c == CH_COLON)
                begin
                    t.emit  = 1'b1;
                    t.res   = mk_res(8'd0, 1'b0, KIND_TRAIL, 1'b1);
                    t.cnt   = sat_inc(cnt);
                    t.phase = PH_TRAIL;
                end
                else if (c != CH_SPACE)
                begin
                    t.emit  = 1'b1;
                    t.res   = mk_res(c, 1'b1, KIND_PARAM, 1'b1);
                    t.cnt   = sat_inc(cnt);
                    t.phase = PH_PARAM;
                end
            end
            PH_PARAM:
            begin
                if (c == CH_SPACE)
                begin
                    t.phase = PH_SEP;
                end
                else
                begin
                    t.emit = 1'b1;
                    t.res  = mk_res(c, 1'b1, KIND_PARAM, 1'b0);
                end
            end
            PH_TRAIL:
            begin
                t.emit = 1'b1;
                t.res  = mk_res(c, 1'b1, KIND_TRAIL, 1'b0);
            end
            PH_ERROR:
            begin
                t.emit = 1'b0;
            end
        endcase
        return t;
    endfunction

    function automatic logic [2:0] line_status_of(state_t st);
        logic [2:0] s;
        unique case (st.phase)
            PH_START:  s = STAT_EMPTY;
            PH_PREFIX: s = STAT_PREFIX_NOSP;
            PH_PRECMD: s = STAT_PREFIX_ONLY;
            PH_ERROR:  s = st.err;
            default:   s = STAT_OK;
        endcase
        return s;
    endfunction

endpackage

// ===== design/irc_line_tokenizer_unit.sv =====
// Streaming tokenizer for text protocol lines: one byte per transfer on s_tdata, token
// results on the m_ side. The block takes one byte per cycle while the result queue has
// room; the phase machine turns the byte in the input register into up to two results,
// which are registered in a small result queue before they are offered. The master side
// drains one result per cycle while m_tready is held high. A byte that follows
// a held CR yields up to two results, but the CR itself yielded none, so a consumer at
// full rate keeps pace. A byte leaves the input register only when the result queue has
// room for two entries; with the default depth of four this never stalls a steady stream
// that the consumer takes at full rate. Token results carry has_byte, token_kind and
// token_start in tuser and the run's last result raises tlast. Every line whose
// end-of-line status is nonzero must be discarded by the consumer, as its tokens were
// passed on before the error was known.
module irc_line_tokenizer_unit
    import irc_tok_pkg::*;
#(
    parameter int OUTQ_DEPTH = OUTQ_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] data_byte, [10:8] line_status, [18:11] param_total
    output logic [4:0]  m_tuser,   // [0] has_byte, [3:1] token_kind, [4] token_start
    output logic        m_tlast    // run_last
);

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    state_t     st_reg;
    state_t     st_next;
    push_t      step_push;
    push_t      q_push;
    logic       room2;
    logic       consume;
    logic       accept;
    result_t    head;

    assign consume  = in_valid_reg && room2;
    assign s_tready = !in_valid_reg || consume;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        q_push   = step_push;
        q_push.n = consume ? step_push.n : 2'd0;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (consume)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    irc_tok_step u_step (
        .rx_byte (in_byte_reg),
        .st      (st_reg),
        .st_next (st_next),
        .push    (step_push)
    );

    irc_tok_outq #(
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .room2      (room2),
        .head_valid (m_tvalid),
        .head_pop   (m_tready),
        .head       (head)
    );

    assign m_tdata = {5'd0, head.param_total, head.line_status, head.data_byte};
    assign m_tuser = {head.token_start, head.token_kind, head.has_byte};
    assign m_tlast = head.run_last;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            st_reg       <= ST_RESET;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (consume)
            begin
                st_reg <= st_next;
            end
        end
    end

`ifndef SYNTH
    a_lf_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && in_byte_reg == CH_LF) |=>
            (st_reg.phase == PH_START && !st_reg.cr_pending && st_reg.cnt == 8'd0))
        else $error("line state not cleared after LF");

    a_cnt_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && in_byte_reg != CH_LF) |=> (st_reg.cnt >= $past(st_reg.cnt)))
        else $error("parameter count fell inside a line");

    a_error_code: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.phase == PH_ERROR) |-> (st_reg.err == STAT_NO_CMD))
        else $error("error phase without the no-command code");
`endif

endmodule

// ===== design/irc_tok_step.sv =====
module irc_tok_step
    import irc_tok_pkg::*;
(
    input  logic [7:0] rx_byte,
    input  state_t     st,
    output state_t     st_next,
    output push_t      push
);

    take_t  t_cr;
    take_t  t_byte;
    state_t st_mid;
    logic   is_lf;
    logic   is_cr;
    logic   emit_cr;
    logic   emit_byte;

    assign is_lf = (rx_byte == CH_LF);
    assign is_cr = (rx_byte == CH_CR);

    // A held CR that turned out not to precede LF is parsed first as a line byte.
    assign t_cr = take_byte(st.phase, st.err, st.cnt, CH_CR);

    always_comb
    begin
        st_mid = st;
        if (st.cr_pending)
        begin
            st_mid.phase = t_cr.phase;
            st_mid.err   = t_cr.err;
            st_mid.cnt   = t_cr.cnt;
        end
        st_mid.cr_pending = 1'b0;
    end

    assign t_byte    = take_byte(st_mid.phase, st_mid.err, st_mid.cnt, rx_byte);
    assign emit_cr   = !is_lf && st.cr_pending && t_cr.emit;
    assign emit_byte = !is_lf && !is_cr && t_byte.emit;

    // Next state.
    always_comb
    begin
        if (is_lf)
        begin
            st_next = ST_RESET;
        end
        else if (is_cr)
        begin
            st_next            = st_mid;
            st_next.cr_pending = 1'b1;
        end
        else
        begin
            st_next            = st_mid;
            st_next.phase      = t_byte.phase;
            st_next.err        = t_byte.err;
            st_next.cnt        = t_byte.cnt;
        end
    end

    // Results.
    always_comb
    begin
        push = '0;
        if (is_lf)
        begin
            push.n              = 2'd1;
            push.r0             = mk_res(8'd0, 1'b0, KIND_EOL, 1'b0);
            push.r0.line_status = line_status_of(st);
            push.r0.param_total = st.cnt;
            push.r0.run_last    = 1'b1;
        end
        else
        begin
            push.n           = {1'b0, emit_cr} + {1'b0, emit_byte};
            push.r0          = emit_cr ? t_cr.res : t_byte.res;
            push.r0.run_last = !(emit_cr && emit_byte);
            push.r1          = t_byte.res;
            push.r1.run_last = 1'b1;
        end
    end

endmodule

// ===== design/irc_tok_outq.sv =====
module irc_tok_outq
    import irc_tok_pkg::*;
#(
    parameter int DEPTH = OUTQ_DEPTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    room2,
    output logic    head_valid,
    input  logic    head_pop,
    output result_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    result_t         entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [PW-1:0]   wr_ptr_2nd;
    logic            pop;

    function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign pop        = head_pop && (count_reg != '0);
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign room2      = (count_reg <= CW'(DEPTH - 2));
    assign wr_ptr_2nd = ptr_inc(wr_ptr_reg);

    always_comb
    begin
        unique case (push.n)
            2'd1:    wr_ptr_next = wr_ptr_2nd;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_2nd);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CW'(push.n) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.n == 2'd2)
        begin
            entry_reg[wr_ptr_2nd] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("result queue count exceeds its depth");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n != 2'd0) |-> (count_reg <= CW'(DEPTH - 2)))
        else $error("results written without room for two entries");

    a_three_never: assert property (@(posedge clk) disable iff (!rst_n)
        push.n != 2'd3)
        else $error("more than two results written in one cycle");
`endif

endmodule
